[rtl/srcs_pkg.sv]
package srcs_pkg;

    localparam int CUR_W   = 16;
    localparam int RREF_W  = 16;
    localparam int HF_W    = 9;
    localparam int RANGE_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int GS_W    = 8;
    localparam int SCALE_W = 5;
    localparam int OUT_DATA_W = 24;

    localparam int MR_W    = CUR_W + RREF_W;
    localparam int PROD_W  = 43;
    localparam int KIFS_W  = 16;
    localparam int DEN_W   = 36;
    localparam int N1_W    = PROD_W + 9;
    localparam int D1_W    = DEN_W + 1;
    localparam int Q1_W    = 8;
    localparam int EFF_W   = 9;
    localparam int EK_W    = 24;
    localparam int EK15_W  = 38;
    localparam int N2_W    = PROD_W + 14;
    localparam int D2_W    = EK15_W + 7;
    localparam int Q2_W    = 6;
    localparam int HPROD_W = SCALE_W + HF_W;

    localparam logic [10:0] SQRT2_MILLI   = 11'd1414;
    localparam logic [13:0] MEGA_ODD      = 14'd15625;
    localparam logic [GS_W-1:0] SCALER_MIN = 8'd32;
    localparam logic [EFF_W-1:0] SCALER_FULL = 9'd256;
    localparam logic [SCALE_W-1:0] SCALE_MAX = 5'd31;

    localparam logic [KIFS_W-1:0] KIFS_TABLE [4] = '{16'd11750, 16'd24000, 16'd36000, 16'd36000};
    localparam logic [DEN_W-1:0] DEN_TABLE [4] = '{
        36'd11750000000, 36'd24000000000, 36'd36000000000, 36'd36000000000
    };

    localparam logic [RANGE_W-1:0] RANGE_RST = 2'd0;
    localparam logic [RREF_W-1:0] RREF_RST   = 16'd12000;
    localparam logic [HF_W-1:0] HF_RST       = 9'd128;

    typedef enum logic [1:0] {
        CFG_CURRENT_RANGE = 2'd0,
        CFG_SENSE_REF     = 2'd1,
        CFG_HOLD_FRACTION = 2'd2
    } cfg_index_t;

endpackage

[rtl/srcs_div_pipe.sv]
module srcs_div_pipe #(
    parameter int NW = 52,
    parameter int DW = 37,
    parameter int QW = 8,
    parameter int PW = 43
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [PW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [QW-1:0] quot,
    output logic          sat,
    output logic [PW-1:0] out_side
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [QW:0]   valid_reg;
    logic [QW:0]   sat_reg;
    logic [CW-1:0] rem_reg  [0:QW];
    logic [DW-1:0] den_reg  [0:QW];
    logic [QW-1:0] q_reg    [0:QW];
    logic [PW-1:0] side_reg [0:QW];

    logic [CW-1:0] trial    [1:QW];
    logic [CW-1:0] rem_next [1:QW];
    logic [QW-1:0] q_next   [1:QW];
    logic [QW:0]   en;
    logic          sat_next;

    always_comb
    begin
        en[QW] = !valid_reg[QW] || out_ready;
        for (int j = QW - 1; j >= 0; j--)
        begin
            en[j] = !valid_reg[j] || en[j+1];
        end
    end

    assign sat_next = CW'(num) >= (CW'(den) << QW);

    // one quotient bit per stage, msb first
    always_comb
    begin
        for (int j = 1; j <= QW; j++)
        begin
            trial[j] = CW'(den_reg[j-1]) << (QW - j);
            if (rem_reg[j-1] >= trial[j])
            begin
                rem_next[j] = rem_reg[j-1] - trial[j];
                q_next[j]   = q_reg[j-1] | (QW'(1) << (QW - j));
            end
            else
            begin
                rem_next[j] = rem_reg[j-1];
                q_next[j]   = q_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int j = 1; j <= QW; j++)
            begin
                if (en[j])
                begin
                    valid_reg[j] <= valid_reg[j-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]  <= CW'(num);
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            sat_reg[0]  <= sat_next;
            side_reg[0] <= in_side;
        end
        for (int j = 1; j <= QW; j++)
        begin
            if (en[j])
            begin
                rem_reg[j]  <= rem_next[j];
                den_reg[j]  <= den_reg[j-1];
                q_reg[j]    <= q_next[j];
                sat_reg[j]  <= sat_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[QW];
    assign quot      = q_reg[QW];
    assign sat       = sat_reg[QW];
    assign out_side  = side_reg[QW];

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[QW] && !sat_reg[QW] |-> rem_reg[QW] < CW'(den_reg[QW]))
        else $error("final remainder not below divisor");

    a_start_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !sat_reg[0] |-> rem_reg[0] < (CW'(den_reg[0]) << QW))
        else $error("unsaturated dividend exceeds quotient range");

endmodule

[rtl/stepper_rms_current_scaler_unit.sv]
// Stepper RMS current scaler.
// Input stream s_axis: one requested RMS current in mA per item.
// Output stream m_axis: global scaler, run scale and hold scale per item.
// Config channel cfg_*: index 0 current range, 1 sense resistor ohms,
// 2 hold fraction (Q1.8); always ready, write only while no item is in flight.
// From input accept to output valid, three stages form the product ma*R*1414,
// a 9-stage restoring divider gives the global scaler, three stages build the
// second divisor, a 7-stage divider gives the run value and one output stage
// forms run and hold scale.
// One item per cycle when not stalled; each stage holds its own valid bit.
// When the receiver stalls, each stage holds only while the next is full, so
// empty stages still fill and input keeps being taken until the pipe is full.
// Reset clears all valid bits and sets the registers to range 0, 12000 ohms,
// hold fraction 128.
module stepper_rms_current_scaler_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [srcs_pkg::CUR_W-1:0]        s_axis_tdata,   // [15:0] current_ma
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [srcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [7:0] global_scale,
                                                              // [12:8] run_scale,
                                                              // [17:13] hold_scale
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [srcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import srcs_pkg::*;

    logic [RANGE_W-1:0] range_reg;
    logic [RREF_W-1:0]  rref_reg;
    logic [HF_W-1:0]    hf_reg;

    logic [DEN_W-1:0]  den_sel;
    logic [KIFS_W-1:0] kifs_sel;

    logic              a_valid_reg, b_valid_reg, c_valid_reg;
    logic              e_valid_reg, f_valid_reg, g_valid_reg, h_valid_reg;
    logic              en_a, en_b, en_c, en_e, en_f, en_g, en_h;

    logic [MR_W-1:0]   mr_reg;
    logic [PROD_W-1:0] prod_b_reg;
    logic [N1_W-1:0]   n1_reg;
    logic [PROD_W-1:0] prod_c_reg;

    logic              d1_in_ready, d1_out_valid, d1_sat;
    logic [Q1_W-1:0]   d1_quot;
    logic [PROD_W-1:0] d1_prod;

    logic [GS_W-1:0]   s_next;
    logic [EFF_W-1:0]  eff_next;
    logic [EK_W-1:0]   ek_next;
    logic [GS_W-1:0]   s_e_reg, s_f_reg, s_g_reg;
    logic [EK_W-1:0]   ek_reg;
    logic [PROD_W-1:0] prod_e_reg, prod_f_reg;
    logic [EK15_W-1:0] ek15_reg;
    logic [N2_W-1:0]   n2_reg;
    logic [D2_W-1:0]   d2_reg;

    logic              d2_in_ready, d2_out_valid, d2_sat;
    logic [Q2_W-1:0]   d2_quot;
    logic [GS_W-1:0]   d2_s;

    logic [SCALE_W-1:0] run_next, hold_next;
    logic [HPROD_W-1:0] hprod;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= RANGE_RST;
            rref_reg  <= RREF_RST;
            hf_reg    <= HF_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CURRENT_RANGE: range_reg <= cfg_data[RANGE_W-1:0];
                CFG_SENSE_REF:     rref_reg  <= cfg_data[RREF_W-1:0];
                CFG_HOLD_FRACTION: hf_reg    <= cfg_data[HF_W-1:0];
                default:           ;
            endcase
        end
    end

    assign den_sel  = DEN_TABLE[range_reg];
    assign kifs_sel = KIFS_TABLE[range_reg];

    // stage enables
    assign en_h = !h_valid_reg || m_axis_tready;
    assign en_g = !g_valid_reg || d2_in_ready;
    assign en_f = !f_valid_reg || en_g;
    assign en_e = !e_valid_reg || en_f;
    assign en_c = !c_valid_reg || d1_in_ready;
    assign en_b = !b_valid_reg || en_c;
    assign en_a = !a_valid_reg || en_b;
    assign s_axis_tready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a) a_valid_reg <= s_axis_tvalid;
            if (en_b) b_valid_reg <= a_valid_reg;
            if (en_c) c_valid_reg <= b_valid_reg;
            if (en_e) e_valid_reg <= d1_out_valid;
            if (en_f) f_valid_reg <= e_valid_reg;
            if (en_g) g_valid_reg <= f_valid_reg;
            if (en_h) h_valid_reg <= d2_out_valid;
        end
    end

    // front: ma*R, *1414, rounding dividend
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            mr_reg <= {{RREF_W{1'b0}}, s_axis_tdata} * {{CUR_W{1'b0}}, rref_reg};
        end
        if (en_b)
        begin
            prod_b_reg <= PROD_W'(mr_reg) * PROD_W'(SQRT2_MILLI);
        end
        if (en_c)
        begin
            n1_reg     <= {prod_b_reg, 9'b0} + N1_W'(den_sel);
            prod_c_reg <= prod_b_reg;
        end
    end

    srcs_div_pipe #(
        .NW (N1_W),
        .DW (D1_W),
        .QW (Q1_W),
        .PW (PROD_W)
    ) u_div_scaler (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .in_ready  (d1_in_ready),
        .num       (n1_reg),
        .den       ({den_sel, 1'b0}),
        .in_side   (prod_c_reg),
        .out_valid (d1_out_valid),
        .out_ready (en_e),
        .quot      (d1_quot),
        .sat       (d1_sat),
        .out_side  (d1_prod)
    );

    // scaler clamp and second divisor
    always_comb
    begin
        if (d1_sat)
        begin
            s_next = '0;
        end
        else if (d1_quot < SCALER_MIN)
        begin
            s_next = SCALER_MIN;
        end
        else
        begin
            s_next = d1_quot;
        end
        eff_next = (s_next == '0) ? SCALER_FULL : EFF_W'(s_next);
        ek_next  = EK_W'({{KIFS_W{1'b0}}, eff_next} * {{EFF_W{1'b0}}, kifs_sel});
    end

    always_ff @(posedge clk)
    begin
        if (en_e)
        begin
            s_e_reg    <= s_next;
            ek_reg     <= ek_next;
            prod_e_reg <= d1_prod;
        end
        if (en_f)
        begin
            s_f_reg    <= s_e_reg;
            ek15_reg   <= EK15_W'(ek_reg) * EK15_W'(MEGA_ODD);
            prod_f_reg <= prod_e_reg;
        end
        if (en_g)
        begin
            s_g_reg <= s_f_reg;
            n2_reg  <= {prod_f_reg, 14'b0} + N2_W'({ek15_reg, 6'b0});
            d2_reg  <= {ek15_reg, 7'b0};
        end
    end

    srcs_div_pipe #(
        .NW (N2_W),
        .DW (D2_W),
        .QW (Q2_W),
        .PW (GS_W)
    ) u_div_run (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid_reg),
        .in_ready  (d2_in_ready),
        .num       (n2_reg),
        .den       (d2_reg),
        .in_side   (s_g_reg),
        .out_valid (d2_out_valid),
        .out_ready (en_h),
        .quot      (d2_quot),
        .sat       (d2_sat),
        .out_side  (d2_s)
    );

    // run and hold
    always_comb
    begin
        if (d2_sat || d2_quot > Q2_W'(SCALE_MAX) + Q2_W'(1))
        begin
            run_next = SCALE_MAX;
        end
        else if (d2_quot == '0)
        begin
            run_next = '0;
        end
        else
        begin
            run_next = SCALE_W'(d2_quot - Q2_W'(1));
        end
        hprod = {{HF_W{1'b0}}, run_next} * {{SCALE_W{1'b0}}, hf_reg};
        if (hprod[HPROD_W-1:8] > (HPROD_W - 8)'(SCALE_MAX))
        begin
            hold_next = SCALE_MAX;
        end
        else
        begin
            hold_next = hprod[8 +: SCALE_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_h)
        begin
            out_data_reg <= {6'b0, hold_next, run_next, d2_s};
        end
    end

    assign m_axis_tvalid = h_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_scaler_range: assert property (@(posedge clk) disable iff (!rst_n)
        h_valid_reg |-> (out_data_reg[7:0] == '0 || out_data_reg[7:0] >= SCALER_MIN))
        else $error("global scaler below minimum");

    a_hold_le_run: assert property (@(posedge clk) disable iff (!rst_n)
        h_valid_reg && hf_reg <= HF_W'(SCALER_FULL) |-> out_data_reg[17:13] <= out_data_reg[12:8])
        else $error("hold scale above run scale");

    a_zero_run_zero_hold: assert property (@(posedge clk) disable iff (!rst_n)
        h_valid_reg && out_data_reg[12:8] == '0 |-> out_data_reg[17:13] == '0)
        else $error("hold scale nonzero with zero run scale");

endmodule

[test/stepper_rms_current_scaler_unit_test.sv]
module stepper_rms_current_scaler_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import srcs_pkg::*;

    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

    localparam longint unsigned KIFS_LOW     = 11750;
    localparam longint unsigned KIFS_MID     = 24000;
    localparam longint unsigned KIFS_HIGH    = 36000;
    localparam longint unsigned ROOT2_X1000  = 1414;
    localparam longint unsigned MICROS       = 1000000;
    localparam longint unsigned SCALER_FLOOR = 32;
    localparam longint unsigned SCALER_WRAP  = 256;
    localparam longint unsigned RUN_GAIN     = 8192;
    localparam longint unsigned SCALE_CEIL   = 31;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int DRAIN_CYCLES    = 30;
    localparam int HOLD_OFF_CYCLES = 200;

    typedef struct packed {
        logic [5:0]  pad;
        logic [4:0]  hold_scale;
        logic [4:0]  run_scale;
        logic [7:0]  global_scale;
    } scale_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [CUR_W-1:0]      s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // settings as the block should hold them
    logic [RANGE_W-1:0] range_sel = RANGE_RST;
    logic [RREF_W-1:0]  sense_ohms = RREF_RST;
    logic [HF_W-1:0]    hold_frac = HF_RST;

    scale_item_t expected_scales [$];
    scale_item_t want_item;
    scale_item_t got_item;
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_req = 0;
    int          hold_off_seen = 0;
    int          hold_off_left = 0;

    stepper_rms_current_scaler_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned round_ratio(input longint unsigned num,
                                                    input longint unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic longint unsigned kifs_of_range();
        case (range_sel)
            2'd0:    return KIFS_LOW;
            2'd1:    return KIFS_MID;
            default: return KIFS_HIGH;
        endcase
    endfunction

    function automatic scale_item_t predict_scales(input logic [CUR_W-1:0] ma);
        longint unsigned prod;
        longint unsigned den;
        longint unsigned scaler;
        longint unsigned eff;
        longint unsigned rounded;
        longint unsigned run;
        longint unsigned hold;
        scale_item_t     item;
        prod = 64'(ma);
        prod = prod * sense_ohms * ROOT2_X1000;
        den = kifs_of_range() * MICROS;
        scaler = round_ratio(prod * SCALER_WRAP, den);
        if (scaler < SCALER_FLOOR)
            scaler = SCALER_FLOOR;
        if (scaler >= SCALER_WRAP)
            scaler = 0;
        eff = (scaler == 0) ? SCALER_WRAP : scaler;
        rounded = round_ratio(prod * RUN_GAIN, eff * den);
        run = (rounded == 0) ? 0 : rounded - 1;
        if (run > SCALE_CEIL)
            run = SCALE_CEIL;
        hold = (run * hold_frac) >> 8;
        if (hold > SCALE_CEIL)
            hold = SCALE_CEIL;
        item = '0;
        item.global_scale = scaler[7:0];
        item.run_scale = run[4:0];
        item.hold_scale = hold[4:0];
        return item;
    endfunction

    // currents biased toward the range where the scales actually move
    function automatic logic [CUR_W-1:0] pick_current();
        longint unsigned full_ma;
        int              sel;
        sel = $urandom_range(99);
        if (sense_ohms == 0)
            full_ma = 65535;
        else
            full_ma = kifs_of_range() * MICROS / (longint'(sense_ohms) * ROOT2_X1000);
        if (full_ma > 32767)
            full_ma = 32767;
        if (sel < 35)
            return CUR_W'($urandom);
        else if (sel < 70)
            return CUR_W'($urandom_range(0, int'(2 * full_ma)));
        else
            return CUR_W'($urandom_range(0, int'(full_ma / 4 + 1)));
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic send_current(input logic [CUR_W-1:0] ma);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ma;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_scales.push_back(predict_scales(ma));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_scales.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_setting(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_CURRENT_RANGE: range_sel = value[RANGE_W-1:0];
            CFG_SENSE_REF:     sense_ohms = value;
            CFG_HOLD_FRACTION: hold_frac = value[HF_W-1:0];
            default: ;
        endcase
    endtask

    // unused upper data bits carry noise
    task automatic load_settings(input logic [RANGE_W-1:0] rng, input logic [RREF_W-1:0] ohms,
                                 input logic [HF_W-1:0] frac);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        write_setting(CFG_CURRENT_RANGE, {noise[CFG_DATA_W-1:RANGE_W], rng});
        write_setting(CFG_SENSE_REF, ohms);
        noise = CFG_DATA_W'($urandom);
        write_setting(CFG_HOLD_FRACTION, {noise[CFG_DATA_W-1:HF_W], frac});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_current(16'd0);
        send_current(16'd1);
        send_current(16'd65535);
        send_current(16'd86);
        send_current(16'd300);
        send_current(16'd692);
        send_current(16'd693);
        send_current(16'h5555);
        send_current(16'hAAAA);
        drain_results();
    endtask

    task automatic test_current_ranges();
        for (int rng = 0; rng < 4; rng++)
        begin
            load_settings(RANGE_W'(rng), RREF_RST, HF_RST);
            send_current(16'd500);
            send_current(16'd40);
            drain_results();
        end
    endtask

    task automatic test_sense_resistor_extremes();
        load_settings(2'd0, 16'd0, HF_RST);
        send_current(16'd1000);
        drain_results();
        load_settings(2'd3, 16'hFFFF, HF_RST);
        send_current(16'd1);
        drain_results();
        load_settings(2'd1, 16'd1, HF_RST);
        send_current(16'd65535);
        drain_results();
    endtask

    task automatic test_hold_fraction();
        load_settings(2'd0, RREF_RST, 9'd0);
        send_current(16'd40);
        drain_results();
        load_settings(2'd0, RREF_RST, 9'd256);
        send_current(16'd80);
        drain_results();
        load_settings(2'd0, RREF_RST, 9'd511);
        send_current(16'd80);
        drain_results();
    endtask

    task automatic test_ignored_index();
        write_setting(CFG_SPARE_INDEX, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_current(16'd80);
        send_current(16'd250);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int                 sel;
        logic [RANGE_W-1:0] rng;
        logic [RREF_W-1:0]  ohms;
        logic [HF_W-1:0]    frac;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin rng = 2'd0; ohms = 16'd12000; frac = 9'd128; end
                1: begin rng = 2'd3; ohms = 16'd60000; frac = 9'd511; end
                2: begin rng = 2'd2; ohms = 16'hFFFF;  frac = 9'd0;   end
                3: begin rng = 2'd1; ohms = 16'd12000; frac = 9'd256; end
                default:
                begin
                    rng = RANGE_W'($urandom_range(3));
                    sel = $urandom_range(9);
                    ohms = (sel == 0) ? 16'hFFFF :
                           (sel == 1) ? 16'($urandom_range(1, 11999)) :
                                        16'($urandom_range(12000, 60000));
                    sel = $urandom_range(9);
                    frac = (sel == 0) ? 9'd256 :
                           (sel == 1) ? 9'($urandom_range(257, 511)) :
                                        9'($urandom_range(0, 256));
                end
            endcase
            load_settings(rng, ohms, frac);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_current(pick_current());
            drain_results();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_settings(2'd1, 16'd30000, 9'd200);
        hold_off_req++;
        for (int n = 0; n < 60; n++)
            send_current(pick_current());
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (hold_off_req != hold_off_seen)
        begin
            hold_off_seen <= hold_off_req;
            hold_off_left <= HOLD_OFF_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_off_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_scales.size() == 0)
            begin
                $display("%0t unexpected item: expected none, actual %h", $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want_item = expected_scales.pop_front();
                got_item = m_axis_tdata;
                check_field("global_scale", 32'(want_item.global_scale),
                            32'(got_item.global_scale));
                check_field("run_scale", 32'(want_item.run_scale), 32'(got_item.run_scale));
                check_field("hold_scale", 32'(want_item.hold_scale), 32'(got_item.hold_scale));
                check_field("pad", 32'(want_item.pad), 32'(got_item.pad));
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_current_ranges();
        test_sense_resistor_extremes();
        test_hold_fraction();
        test_ignored_index();
        test_random_traffic();
        test_backpressure();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("%0t timeout", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
